>>> hdl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform package
// Word types and shared constants of the 4x4 fixed-point transform.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgW = 64;

  // Command codes of an input word.
  localparam logic CmdDirection = 1'b0;
  localparam logic CmdPoint = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     saturated;
    logic                     w_zero;
  } out_word_t;

endpackage

`default_nettype wire

>>> hdl/hpt_column.sv
// ----------------------------------------------------------------------------
// Matrix column unit
// Pipelined dot product of the coordinate with one matrix column: products,
// sum, floor shift and clamp, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_column #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic               clk_i,
  input  wire logic [2:0]         en_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  input  wire logic signed [31:0] z_i,
  input  wire logic signed [31:0] m0_i,
  input  wire logic signed [31:0] m1_i,
  input  wire logic signed [31:0] m2_i,
  input  wire logic signed [31:0] off_i,
  input  wire logic               affine_i,
  output logic signed [31:0]      sum_o,
  output logic                    sat_o
);

  logic signed [63:0] p0_q, p1_q, p2_q;
  logic signed [31:0] off_q;
  logic signed [65:0] acc_q;
  logic signed [65:0] acc_d;
  logic signed [65:0] sh;

  // Stage 1: the three products and the offset.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p0_q  <= x_i * m0_i;
      p1_q  <= y_i * m1_i;
      p2_q  <= z_i * m2_i;
      off_q <= affine_i ? off_i : 32'sd0;
    end
  end

  // Stage 2: exact sum; the offset sits at the fraction scale.
  assign acc_d = 66'(p0_q) + 66'(p1_q) + 66'(p2_q) + (66'(off_q) <<< FracBits);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      acc_q <= acc_d;
    end
  end

  // Stage 3: floor shift and clamp to 32 bits.
  assign sh = acc_q >>> FracBits;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      if (sh > 66'sd2147483647) begin
        sum_o <= 32'sh7fffffff;
        sat_o <= 1'b1;
      end else if (sh < -66'sd2147483648) begin
        sum_o <= 32'sh80000000;
        sat_o <= 1'b1;
      end else begin
        sum_o <= sh[31:0];
        sat_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/hpt_divider.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Signed (v << FracBits) / w truncated toward zero with a 32-bit clamp.
// One quotient bit per stage over a chain of registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_divider #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] v_i,
  input  wire logic signed [31:0] w_i,
  output logic signed [31:0]      q_o,
  output logic                    sat_o
);

  localparam int unsigned NumW = 32 + FracBits;
  localparam int unsigned Steps = NumW;

  logic [NumW-1:0] num_q [Steps+1];
  logic [NumW-1:0] quo_q [Steps+1];
  logic [NumW:0]   rem_q [Steps+1];
  logic [31:0]     den_q [Steps+1];
  logic            neg_q [Steps+1];

  logic [31:0] v_mag, w_mag;

  assign v_mag = v_i[31] ? 32'(-v_i) : 32'(v_i);
  assign w_mag = w_i[31] ? 32'(-w_i) : 32'(w_i);

  // Entry of the operand magnitudes.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= {v_mag, FracBits'(0)};
      quo_q[0] <= '0;
      rem_q[0] <= '0;
      den_q[0] <= w_mag;
      neg_q[0] <= v_i[31] ^ w_i[31];
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [NumW:0] trial;
    assign trial = {rem_q[s][NumW-1:0], num_q[s][NumW-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_q[s] << 1;
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        if (trial >= (NumW+1)'(den_q[s])) begin
          rem_q[s+1] <= trial - (NumW+1)'(den_q[s]);
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= trial;
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b0};
        end
      end
    end
  end

  // Sign and clamp.
  logic [NumW:0] mag;
  assign mag = {1'b0, quo_q[Steps]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[Steps]) begin
        if (mag > (NumW+1)'(33'h080000000)) begin
          q_o <= 32'sh80000000;
          sat_o <= 1'b1;
        end else begin
          q_o <= 32'(-mag[31:0]);
          sat_o <= 1'b0;
        end
      end else if (mag > (NumW+1)'(33'h07fffffff)) begin
        q_o <= 32'sh7fffffff;
        sat_o <= 1'b1;
      end else begin
        q_o <= mag[31:0];
        sat_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/homogeneous_point_transform_top.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform, top level
// Row vector times a configured Q16.16 4x4 matrix, with perspective divide.
// ----------------------------------------------------------------------------
// Usage: input words (command, x, y, z) arrive on in_valid_i/in_stall_o and
// results leave on out_valid_o/out_stall_i; a word moves when valid is high
// and stall is low. The matrix is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while no word is in flight; indices above seven are ignored.
// Throughput is one word per cycle while the output is not stalled. A word
// passes the column units, the divider operand stage and the divider
// (operand entry, one stage per quotient bit and the sign stage) before
// its result can be taken; the divider chain is the longest part of the path.
// Every word takes the same path, so order is kept.
// When the receiver stalls a valid result, the whole pipeline holds (the
// input stall follows it) and nothing is lost or repeated; while the output
// holds no word the pipeline keeps moving whatever out_stall_i is.
// Reset clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire hpt_pkg::in_word_t     in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output hpt_pkg::out_word_t         out_word_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [63:0]           cfg_data_i
);

  localparam int unsigned DivLat = FRAC_BITS + 34;
  localparam int unsigned Lat = DivLat + 4;
  localparam logic [31:0] One = 32'(1) << FRAC_BITS;

  // Matrix registers.
  logic [63:0] mat_q [hpt_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= 64'(One);
      mat_q[1] <= '0;
      mat_q[2] <= {One, 32'd0};
      mat_q[3] <= '0;
      mat_q[4] <= '0;
      mat_q[5] <= 64'(One);
      mat_q[6] <= '0;
      mat_q[7] <= {One, 32'd0};
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  function automatic logic signed [31:0] ent(input logic [63:0] m [8], input int i,
                                             input int j);
    logic [63:0] p;
    p = m[3'((4 * i + j) >> 1)];
    return j[0] ? p[63:32] : p[31:0];
  endfunction

  // Global advance: the pipeline moves unless a held output is stalled.
  logic adv;
  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] cmd_q;

  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) cmd_q <= {cmd_q[Lat-2:0], in_word_i.command};
  end

  assign out_valid_o = vld_q[Lat-1];

  // Four column units.
  logic signed [31:0] col_sum [4];
  logic               col_sat [4];

  for (genvar j = 0; j < 4; j++) begin : g_col
    hpt_column #(.FracBits(FRAC_BITS)) u_col (
      .clk_i   (clk_i),
      .en_i    ({3{adv}}),
      .x_i     (in_word_i.in_x),
      .y_i     (in_word_i.in_y),
      .z_i     (in_word_i.in_z),
      .m0_i    (ent(mat_q, 0, j)),
      .m1_i    (ent(mat_q, 1, j)),
      .m2_i    (ent(mat_q, 2, j)),
      .off_i   (ent(mat_q, 3, j)),
      .affine_i(in_word_i.command == hpt_pkg::CmdPoint),
      .sum_o   (col_sum[j]),
      .sat_o   (col_sat[j])
    );
  end

  // Divider operand stage: w of one means divide by one (exact pass-through).
  logic signed [31:0] sx_q, sy_q, sz_q, w_q;
  logic sat3_q, wz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= col_sum[0];
      sy_q <= col_sum[1];
      sz_q <= col_sum[2];
      if (cmd_q[2] == hpt_pkg::CmdPoint) begin
        w_q    <= (col_sum[3] == 32'sd0) ? One : col_sum[3];
        wz_q   <= (col_sum[3] == 32'sd0);
        sat3_q <= col_sat[0] | col_sat[1] | col_sat[2] | col_sat[3];
      end else begin
        w_q    <= One;
        wz_q   <= 1'b0;
        sat3_q <= col_sat[0] | col_sat[1] | col_sat[2];
      end
    end
  end

  // Flag delay alongside the divider.
  logic [DivLat-1:0] sat_dl_q, wz_dl_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sat_dl_q <= {sat_dl_q[DivLat-2:0], sat3_q};
      wz_dl_q  <= {wz_dl_q[DivLat-2:0], wz_q};
    end
  end

  logic signed [31:0] qx, qy, qz;
  logic sx_s, sy_s, sz_s;

  hpt_divider #(.FracBits(FRAC_BITS)) u_div_x (
    .clk_i(clk_i), .en_i(adv), .v_i(sx_q), .w_i(w_q), .q_o(qx), .sat_o(sx_s));
  hpt_divider #(.FracBits(FRAC_BITS)) u_div_y (
    .clk_i(clk_i), .en_i(adv), .v_i(sy_q), .w_i(w_q), .q_o(qy), .sat_o(sy_s));
  hpt_divider #(.FracBits(FRAC_BITS)) u_div_z (
    .clk_i(clk_i), .en_i(adv), .v_i(sz_q), .w_i(w_q), .q_o(qz), .sat_o(sz_s));

  // Result word.
  logic wz_out;
  assign wz_out = wz_dl_q[DivLat-1];

  always_comb begin
    out_word_o.out_x     = wz_out ? 32'sd0 : qx;
    out_word_o.out_y     = wz_out ? 32'sd0 : qy;
    out_word_o.out_z     = wz_out ? 32'sd0 : qz;
    out_word_o.w_zero    = wz_out;
    out_word_o.saturated = !wz_out && (sat_dl_q[DivLat-1] | sx_s | sy_s | sz_s);
  end

  // A stalled output word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // Input is stalled exactly when the output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("stall mismatch");

  // A zero-w result carries zero coordinates and no saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.w_zero |-> !out_word_o.saturated &&
      out_word_o.out_x == 32'sd0)
    else $error("w_zero result not cleared");

endmodule

`default_nettype wire
